// ===== rtl/rotary_encoder_menu_control_top_assert.svh =====
// Assertion macros for the rotary encoder menu controller checker.
// Uses no other file; the including module must provide clk and arst_n.
`ifndef ROTARY_ENCODER_MENU_CONTROL_TOP_ASSERT_SVH
`define ROTARY_ENCODER_MENU_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define REMC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("remc assertion failed");

// Next-cycle implication, disabled during reset.
`define REMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("remc assertion failed");

`endif

// ===== rtl/remc_pkg.sv =====
// Shared types, codes and constants of the rotary encoder menu controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package remc_pkg;

	localparam int ActionW   = 2;
	localparam int LevelW    = 8;
	localparam int MsW       = 16;
	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;

	// Event codes.
	localparam logic [ActionW-1:0] ACT_TICK    = 2'd0;
	localparam logic [ActionW-1:0] ACT_ENCODER = 2'd1;
	localparam logic [ActionW-1:0] ACT_PRESS   = 2'd2;
	localparam logic [ActionW-1:0] ACT_INIT    = 2'd3;

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] REG_BRIGHTNESS_STEP = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_BUTTON_HOLDOFF  = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_BLINK_INIT      = 2'd2;
	localparam logic [CfgIndexW-1:0] REG_BRIGHT_INIT     = 2'd3;

	localparam logic [LevelW-1:0] LEVEL_MAX          = 8'd255;
	localparam logic [LevelW-1:0] BLINK_STEP         = 8'd1;
	localparam logic [LevelW-1:0] STEP_RESET         = 8'd1;
	localparam logic [MsW-1:0]    HOLDOFF_RESET      = 16'd200;

	localparam int DEF_NUM_OPTIONS      = 4;
	localparam int DEF_BLINK_ENTRY      = 0;
	localparam int DEF_BRIGHTNESS_ENTRY = 1;

	typedef struct packed {
		logic [ActionW-1:0] action;
		logic               pin_a;
		logic               pin_b;
	} remc_item_t;

	typedef struct packed {
		logic [LevelW-1:0] brightness_step;
		logic [MsW-1:0]    button_holdoff_ms;
		logic [LevelW-1:0] blink_init;
		logic [LevelW-1:0] bright_init;
	} remc_cfg_t;

	typedef struct packed {
		logic [1:0]        menu_index;
		logic [3:0]        edit_flags;
		logic [LevelW-1:0] blink_value;
		logic [LevelW-1:0] brightness_value;
		logic              press_parity;
		logic              event_taken;
	} remc_result_t;

	// Moves a level up or down by an amount, saturating at 0 and LEVEL_MAX.
	function automatic logic [LevelW-1:0] apply_level(
		input logic [LevelW-1:0] level,
		input logic              up,
		input logic [LevelW-1:0] amount
	);
		logic [LevelW:0] sum;
		logic [LevelW-1:0] res;
		sum = {1'b0, level} + {1'b0, amount};
		if (up) begin
			res = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LevelW-1:0];
		end else begin
			res = (amount > level) ? '0 : level - amount;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/remc_update.sv =====
// Controller state and its single-pass next-state logic for one event.
// Depends on remc_pkg for the event codes, item, config and result types.
`default_nettype none

module remc_update import remc_pkg::*; #(
	parameter int NUM_OPTIONS      = DEF_NUM_OPTIONS,
	parameter int BLINK_ENTRY      = DEF_BLINK_ENTRY,
	parameter int BRIGHTNESS_ENTRY = DEF_BRIGHTNESS_ENTRY
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step_en,
	input  wire remc_item_t   item,
	input  wire remc_cfg_t    cfg,
	output remc_result_t      result
);

	localparam int CursorW = $clog2(NUM_OPTIONS);
	localparam int OutCW   = (CursorW > 2) ? CursorW : 2;
	localparam int FlagW   = (NUM_OPTIONS > 4) ? NUM_OPTIONS : 4;
	localparam logic [CursorW-1:0] LAST_ENTRY = CursorW'(NUM_OPTIONS - 1);

	logic [CursorW-1:0]     cursor_q, cursor_d;
	logic [NUM_OPTIONS-1:0] edit_q, edit_d;
	logic [LevelW-1:0]      blink_q, blink_d;
	logic [LevelW-1:0]      bright_q, bright_d;
	logic                   last_a_q, last_a_d;
	logic                   last_up_q, last_up_d;
	logic                   rot_q, rot_d;
	logic [MsW-1:0]         ms_q, ms_d;
	logic                   toggle_q, toggle_d;
	logic                   taken;
	logic                   move;
	logic                   up;
	logic                   editing;
	logic [NUM_OPTIONS-1:0] cursor_sel;
	logic [OutCW-1:0]       cursor_wide;
	logic [FlagW-1:0]       flags_wide;

	assign editing    = edit_q[cursor_q];
	assign cursor_sel = NUM_OPTIONS'(1) << cursor_q;

	always_comb begin
		cursor_d  = cursor_q;
		edit_d    = edit_q;
		blink_d   = blink_q;
		bright_d  = bright_q;
		last_a_d  = last_a_q;
		last_up_d = last_up_q;
		rot_d     = rot_q;
		ms_d      = ms_q;
		toggle_d  = toggle_q;
		taken     = 1'b1;
		move      = 1'b0;
		up        = 1'b0;
		case (item.action)
			ACT_TICK: begin
				if (ms_q != '1) begin
					ms_d = ms_q + 1'b1;
				end
				rot_d = 1'b1;
			end
			ACT_ENCODER: begin
				// Only one encoder event per millisecond is decoded.
				if (!rot_q) begin
					taken = 1'b0;
				end else begin
					if (last_up_q && last_a_q && !item.pin_a && item.pin_b) begin
						move = 1'b1;
						up   = 1'b0;
					end else if (!last_a_q && item.pin_a) begin
						move = 1'b1;
						up   = item.pin_b;
					end
					if (move) begin
						last_up_d = up;
					end
					last_a_d = item.pin_a;
					rot_d    = 1'b0;
					if (move) begin
						if (!editing) begin
							if (up) begin
								cursor_d = (cursor_q == LAST_ENTRY) ? '0 : cursor_q + 1'b1;
							end else begin
								cursor_d = (cursor_q == '0) ? LAST_ENTRY : cursor_q - 1'b1;
							end
						end else if (int'(cursor_q) == BRIGHTNESS_ENTRY) begin
							bright_d = apply_level(bright_q, up, cfg.brightness_step);
						end else if (int'(cursor_q) == BLINK_ENTRY) begin
							blink_d = apply_level(blink_q, up, BLINK_STEP);
						end
					end
				end
			end
			ACT_PRESS: begin
				if (ms_q > cfg.button_holdoff_ms) begin
					toggle_d = ~toggle_q;
					// Toggle the entry under the cursor and clear all others.
					edit_d   = ~edit_q & cursor_sel;
					ms_d     = '0;
				end else begin
					taken = 1'b0;
				end
			end
			ACT_INIT: begin
				blink_d  = cfg.blink_init;
				bright_d = cfg.bright_init;
				toggle_d = 1'b0;
			end
			default: begin
				taken = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			edit_q    <= '0;
			blink_q   <= '0;
			bright_q  <= '0;
			last_a_q  <= 1'b0;
			last_up_q <= 1'b0;
			rot_q     <= 1'b0;
			ms_q      <= '0;
			toggle_q  <= 1'b0;
		end else if (step_en) begin
			cursor_q  <= cursor_d;
			edit_q    <= edit_d;
			blink_q   <= blink_d;
			bright_q  <= bright_d;
			last_a_q  <= last_a_d;
			last_up_q <= last_up_d;
			rot_q     <= rot_d;
			ms_q      <= ms_d;
			toggle_q  <= toggle_d;
		end
	end

	assign cursor_wide = OutCW'(cursor_d);
	assign flags_wide  = FlagW'(edit_d);

	always_comb begin
		result.menu_index       = cursor_wide[1:0];
		result.edit_flags       = flags_wide[3:0];
		result.blink_value      = blink_d;
		result.brightness_value = bright_d;
		result.press_parity     = toggle_d;
		result.event_taken      = taken;
	end

endmodule

`default_nettype wire

// ===== rtl/rotary_encoder_menu_control_top.sv =====
// Top level of the rotary encoder menu controller: ports, configuration
// registers, input register and result register. Depends on remc_pkg, remc_update.
`default_nettype none

// Takes one event per transfer (tick, encoder change, button press, init) and
// returns one result per event: cursor, edit flags, blink and brightness levels,
// press parity and whether the event was taken or held off. The block sustains
// one event per clock cycle unless the result stalls. An event is held in the input
// register while the single-pass update logic computes the next controller
// state and the result; both are loaded when the event advances, and the result
// port is driven from the result register. A stalled result holds the input
// register, and ready drops once both are full. Configuration writes take
// effect at once and belong in idle periods.
module rotary_encoder_menu_control_top import remc_pkg::*; #(
	parameter int NUM_OPTIONS      = DEF_NUM_OPTIONS,
	parameter int BLINK_ENTRY      = DEF_BLINK_ENTRY,
	parameter int BRIGHTNESS_ENTRY = DEF_BRIGHTNESS_ENTRY
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ActionW-1:0]   action,
	input  wire logic                 pin_a,
	input  wire logic                 pin_b,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                menu_index,
	output logic [3:0]                edit_flags,
	output logic [LevelW-1:0]         blink_value,
	output logic [LevelW-1:0]         brightness_value,
	output logic                      press_parity,
	output logic                      event_taken,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	remc_cfg_t    cfg_q;
	remc_item_t   item_s1;
	logic         valid_s1;
	remc_result_t result;
	remc_result_t result_q;
	logic         out_valid_q;
	logic         advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness_step   <= STEP_RESET;
			cfg_q.button_holdoff_ms <= HOLDOFF_RESET;
			cfg_q.blink_init        <= '0;
			cfg_q.bright_init       <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BRIGHTNESS_STEP: cfg_q.brightness_step   <= cfg_data[LevelW-1:0];
				REG_BUTTON_HOLDOFF:  cfg_q.button_holdoff_ms <= cfg_data[MsW-1:0];
				REG_BLINK_INIT:      cfg_q.blink_init        <= cfg_data[LevelW-1:0];
				REG_BRIGHT_INIT:     cfg_q.bright_init       <= cfg_data[LevelW-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The held event moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action <= action;
			item_s1.pin_a  <= pin_a;
			item_s1.pin_b  <= pin_b;
		end
	end

	remc_update #(
		.NUM_OPTIONS      (NUM_OPTIONS),
		.BLINK_ENTRY      (BLINK_ENTRY),
		.BRIGHTNESS_ENTRY (BRIGHTNESS_ENTRY)
	) u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign menu_index       = result_q.menu_index;
	assign edit_flags       = result_q.edit_flags;
	assign blink_value      = result_q.blink_value;
	assign brightness_value = result_q.brightness_value;
	assign press_parity     = result_q.press_parity;
	assign event_taken      = result_q.event_taken;

endmodule

`default_nettype wire

// ===== rtl/remc_checker.sv =====
// Port-level checker for the rotary encoder menu controller, bound to the top.
// Depends on remc_pkg and rotary_encoder_menu_control_top_assert.svh.
`default_nettype none

`include "rotary_encoder_menu_control_top_assert.svh"

module remc_checker import remc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic [ActionW-1:0]   action,
	input wire logic                 pin_a,
	input wire logic                 pin_b,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [1:0]           menu_index,
	input wire logic [3:0]           edit_flags,
	input wire logic [LevelW-1:0]    blink_value,
	input wire logic [LevelW-1:0]    brightness_value,
	input wire logic                 press_parity,
	input wire logic                 event_taken
);

	// At most one entry is ever in edit.
	`REMC_ASSERT_NOW(a_edit_onehot, out_valid, $onehot0(edit_flags))

	// The cursor cannot leave an entry that is in edit.
	`REMC_ASSERT_NOW(a_edit_at_cursor, out_valid && (edit_flags != 4'd0),
		edit_flags[menu_index])

	// A stalled result stays on the port unchanged.
	`REMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(menu_index) && $stable(edit_flags) && $stable(blink_value)
		&& $stable(brightness_value) && $stable(press_parity) && $stable(event_taken))

	// A waiting input transfer keeps its payload.
	`REMC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(action) && $stable(pin_a) && $stable(pin_b))

endmodule

bind rotary_encoder_menu_control_top remc_checker u_remc_checker (.*);

`default_nettype wire
